// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// File: hw/rtl/lbbc_pkg.sv
// ----------------------------------------------------------------------------
// lbbc_pkg
// Constants, register indexes and helpers of the LED blink/breathe core.
// ----------------------------------------------------------------------------
package lbbc_pkg;

   // Breathing PWM resolution and the widths that follow from it.
   localparam int PWM_STEPS = 100;
   localparam int PWM_W     = $clog2(PWM_STEPS + 1);

   localparam int TICK_W   = 32;
   localparam int PERIOD_W = 16;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // Duty step interval is the breathing period divided by this value.
   localparam int STEP_DIV   = 200;
   localparam int STEP_W     = $clog2((2 ** PERIOD_W - 1) / STEP_DIV + 1);
   localparam int RECIP_SH   = 24;
   localparam int RECIP      = (2 ** RECIP_SH) / STEP_DIV + 1;
   localparam int RECIP_W    = $clog2(RECIP + 1);
   localparam int PROD_W     = PERIOD_W + RECIP_W;

   // Interval values after reset and after a timed blink runs out.
   localparam logic [TICK_W-1:0] BLINK_DEF_ON  = TICK_W'(500);
   localparam logic [TICK_W-1:0] BLINK_DEF_OFF = TICK_W'(500);

   // Register indexes on the configuration port.
   localparam logic [CSR_AW-1:0] REG_MODE     = CSR_AW'(0);
   localparam logic [CSR_AW-1:0] REG_ON_TIME  = CSR_AW'(1);
   localparam logic [CSR_AW-1:0] REG_OFF_TIME = CSR_AW'(2);
   localparam logic [CSR_AW-1:0] REG_DURATION = CSR_AW'(3);
   localparam logic [CSR_AW-1:0] REG_PERIOD   = CSR_AW'(4);

   // Mode register codes.
   localparam logic [1:0] MODE_OFF     = 2'd0;
   localparam logic [1:0] MODE_ON      = 2'd1;
   localparam logic [1:0] MODE_BLINK   = 2'd2;
   localparam logic [1:0] MODE_BREATHE = 2'd3;

   // The reciprocal is exact over the whole 16-bit period range.
   function automatic logic [STEP_W-1:0] step_interval(input logic [PERIOD_W-1:0] period);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(period) * PROD_W'(RECIP);
      return STEP_W'(prod >> RECIP_SH);
   endfunction

endpackage

// File: hw/rtl/led_blink_breathe_controller_core.sv
// ----------------------------------------------------------------------------
// led_blink_breathe_controller_core
// LED controller with off, on, timed blink and PWM breathing modes.
// ----------------------------------------------------------------------------
// Each word on the req_ stream is one service step carrying the current
// millisecond timestamp. Every step returns exactly one rsp_ word with the
// LED level and a flag that says whether the level was driven in that step.
// The csr_ port selects the mode and sets the blink and breathing timing;
// writing the mode register restarts the selected mode. Blink intervals are
// latched on that write, while the breathing period is used as written.
// A step accepted on req_ shows on rsp_ in the next cycle.
// Throughput is one step per cycle while the receiver takes each word; the
// step logic is a single pass of 32-bit subtract/compare and small counter
// updates between the state registers and the output register.
// req_tready stays high while the output register is empty or being taken,
// so a stalled receiver holds one word and then back-pressures the input.
// Reset (synchronous) sets all state but the output data bits: mode off pending,
// blink intervals 500/500 with no duration, breathing period zero, output register empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module led_blink_breathe_controller_core
   import lbbc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // Service steps
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // [31:0] now_tick
   // Results
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // [0] led_on, [1] led_driven, [7:2] zero
   // Configuration
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      AM_OFF, AM_ON, AM_BLINK, AM_BREATHE, AM_IDLE
   } mode_type;

   typedef enum logic [1:0] {
      PH_FIRST, PH_LIT, PH_DARK
   } phase_type;

   // Configuration registers
   logic [TICK_W-1:0] on_time_ff,  on_time_in;
   logic [TICK_W-1:0] off_time_ff, off_time_in;
   logic [TICK_W-1:0] duration_ff, duration_in;
   logic [STEP_W-1:0] step_ival_ff, step_ival_in;

   // Mode state
   mode_type          active_ff, active_in;
   phase_type         phase_ff,  phase_in;
   logic [TICK_W-1:0] lit_since_ff,  lit_since_in;
   logic [TICK_W-1:0] dark_since_ff, dark_since_in;
   logic [TICK_W-1:0] run_since_ff,  run_since_in;
   logic [TICK_W-1:0] live_on_ff,  live_on_in;
   logic [TICK_W-1:0] live_off_ff, live_off_in;
   logic [TICK_W-1:0] live_dur_ff, live_dur_in;
   logic [PWM_W-1:0]  pwm_count_ff, pwm_count_in;
   logic [PWM_W-1:0]  duty_ff, duty_in;
   logic              rising_ff, rising_in;
   logic [TICK_W-1:0] last_step_ff, last_step_in;

   // Output register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_on_ff,     rsp_on_in;
   logic rsp_driven_ff, rsp_driven_in;

   logic              req_accept;
   logic [TICK_W-1:0] now;
   logic              step_lit;
   logic              step_driven;
   logic [PWM_W-1:0]  pwm_inc;
   logic [PWM_W-1:0]  duty_step;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign now        = req_tdata[TICK_W-1:0];
   assign pwm_inc    = pwm_count_ff + PWM_W'(1);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_driven_ff, rsp_on_ff};

   always_comb begin
      on_time_in    = on_time_ff;
      off_time_in   = off_time_ff;
      duration_in   = duration_ff;
      step_ival_in  = step_ival_ff;
      active_in     = active_ff;
      phase_in      = phase_ff;
      lit_since_in  = lit_since_ff;
      dark_since_in = dark_since_ff;
      run_since_in  = run_since_ff;
      live_on_in    = live_on_ff;
      live_off_in   = live_off_ff;
      live_dur_in   = live_dur_ff;
      pwm_count_in  = pwm_count_ff;
      duty_in       = duty_ff;
      rising_in     = rising_ff;
      last_step_in  = last_step_ff;
      step_lit      = 1'b0;
      step_driven   = 1'b0;
      duty_step     = duty_ff;

      if (req_accept) begin
         case (active_ff)
            AM_OFF: begin
               step_driven = 1'b1;
               active_in   = AM_IDLE;
            end
            AM_ON: begin
               step_driven = 1'b1;
               step_lit    = 1'b1;
               active_in   = AM_IDLE;
            end
            AM_BLINK: begin
               if (live_dur_ff != '0 && phase_ff != PH_FIRST &&
                   (now - run_since_ff) >= live_dur_ff) begin
                  // A timed blink has run out: go dark and fall back to an
                  // endless default blink.
                  step_driven   = 1'b1;
                  phase_in      = PH_FIRST;
                  lit_since_in  = '0;
                  dark_since_in = '0;
                  run_since_in  = '0;
                  live_on_in    = BLINK_DEF_ON;
                  live_off_in   = BLINK_DEF_OFF;
                  live_dur_in   = '0;
               end else if (phase_ff == PH_LIT) begin
                  if ((now - lit_since_ff) >= live_on_ff) begin
                     step_driven   = 1'b1;
                     dark_since_in = now;
                     phase_in      = PH_DARK;
                  end
               end else if (phase_ff == PH_DARK) begin
                  if ((now - dark_since_ff) >= live_off_ff) begin
                     step_driven  = 1'b1;
                     step_lit     = 1'b1;
                     lit_since_in = now;
                     phase_in     = PH_LIT;
                  end
               end else begin
                  step_driven  = 1'b1;
                  step_lit     = 1'b1;
                  lit_since_in = now;
                  run_since_in = now;
                  phase_in     = PH_LIT;
               end
            end
            AM_BREATHE: begin
               step_driven  = 1'b1;
               step_lit     = pwm_inc < duty_ff;
               pwm_count_in = (pwm_inc >= PWM_W'(PWM_STEPS)) ? '0 : pwm_inc;
               if ((now - last_step_ff) >= TICK_W'(step_ival_ff)) begin
                  last_step_in = now;
                  if (rising_ff) begin
                     if (duty_ff < PWM_W'(PWM_STEPS)) begin
                        duty_step = duty_ff + PWM_W'(1);
                     end
                     if (duty_step >= PWM_W'(PWM_STEPS)) begin
                        rising_in = 1'b0;
                     end
                  end else begin
                     if (duty_ff != '0) begin
                        duty_step = duty_ff - PWM_W'(1);
                     end
                     if (duty_step == '0) begin
                        rising_in = 1'b1;
                     end
                  end
                  duty_in = duty_step;
               end
            end
            default: begin
               step_driven = 1'b0;
            end
         endcase
      end

      if (csr_we) begin
         case (csr_addr)
            REG_MODE: begin
               case (csr_wdata[1:0])
                  MODE_OFF: active_in = AM_OFF;
                  MODE_ON:  active_in = AM_ON;
                  MODE_BLINK: begin
                     active_in     = AM_BLINK;
                     phase_in      = PH_FIRST;
                     lit_since_in  = '0;
                     dark_since_in = '0;
                     run_since_in  = '0;
                     live_on_in    = on_time_ff;
                     live_off_in   = off_time_ff;
                     live_dur_in   = duration_ff;
                  end
                  default: begin
                     active_in    = AM_BREATHE;
                     pwm_count_in = '0;
                     last_step_in = '0;
                     duty_in      = '0;
                     rising_in    = 1'b0;
                  end
               endcase
            end
            REG_ON_TIME:  on_time_in   = csr_wdata[TICK_W-1:0];
            REG_OFF_TIME: off_time_in  = csr_wdata[TICK_W-1:0];
            REG_DURATION: duration_in  = csr_wdata[TICK_W-1:0];
            REG_PERIOD:   step_ival_in = step_interval(csr_wdata[PERIOD_W-1:0]);
            default: begin
               step_ival_in = step_ival_ff;
            end
         endcase
      end

      if (req_accept) begin
         rsp_valid_in  = 1'b1;
         rsp_on_in     = step_lit;
         rsp_driven_in = step_driven;
      end else begin
         rsp_valid_in  = rsp_valid_ff && !rsp_tready;
         rsp_on_in     = rsp_on_ff;
         rsp_driven_in = rsp_driven_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_time_ff    <= BLINK_DEF_ON;
         off_time_ff   <= BLINK_DEF_OFF;
         duration_ff   <= '0;
         step_ival_ff  <= '0;
         active_ff     <= AM_OFF;
         phase_ff      <= PH_FIRST;
         lit_since_ff  <= '0;
         dark_since_ff <= '0;
         run_since_ff  <= '0;
         live_on_ff    <= BLINK_DEF_ON;
         live_off_ff   <= BLINK_DEF_OFF;
         live_dur_ff   <= '0;
         pwm_count_ff  <= '0;
         duty_ff       <= '0;
         rising_ff     <= 1'b0;
         last_step_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         on_time_ff    <= on_time_in;
         off_time_ff   <= off_time_in;
         duration_ff   <= duration_in;
         step_ival_ff  <= step_ival_in;
         active_ff     <= active_in;
         phase_ff      <= phase_in;
         lit_since_ff  <= lit_since_in;
         dark_since_ff <= dark_since_in;
         run_since_ff  <= run_since_in;
         live_on_ff    <= live_on_in;
         live_off_ff   <= live_off_in;
         live_dur_ff   <= live_dur_in;
         pwm_count_ff  <= pwm_count_in;
         duty_ff       <= duty_in;
         rising_ff     <= rising_in;
         last_step_ff  <= last_step_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_on_ff     <= rsp_on_in;
      rsp_driven_ff <= rsp_driven_in;
   end

   // Every accepted step must leave a word in the output register.
   `ASSERT_NEXT(a_step_gives_word, req_accept, rsp_valid_ff, "accepted step produced no word")

   // Once idle, a step drives nothing.
   `ASSERT_NEXT(a_idle_not_driven, req_accept && !csr_we && active_ff == AM_IDLE,
                !rsp_driven_ff, "idle step drove the LED")

   // The breathing counters stay inside the PWM range.
   `ASSERT_CLK(a_pwm_range,
               pwm_count_ff < PWM_W'(PWM_STEPS) && duty_ff <= PWM_W'(PWM_STEPS),
               "PWM count or duty out of range")

endmodule

// File: dv/tb_led_blink_breathe_controller_core.sv
// ----------------------------------------------------------------------------
// tb_led_blink_breathe_controller_core
// Self-checking bench for the LED off/on/blink/breathing core.
// ----------------------------------------------------------------------------
// A short scripted sequence hits the reset state, on/off one-shots, zero
// blink intervals, a timed blink running out and breathing at both period
// extremes. Random phases follow: each one reprograms the registers while
// the core is quiet, then streams timestamps that mostly creep forward and
// sometimes jump. A step-level predictor in this file produces the expected
// word for each step not typed in the script, and both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_led_blink_breathe_controller_core;
   import lbbc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_STEPS = 1200;

   typedef enum logic [2:0] {ACT_OFF, ACT_ON, ACT_BLINK, ACT_BREATHE, ACT_IDLE} act_type;
   typedef enum logic [1:0] {PH_FIRST, PH_LIT, PH_DARK} blink_ph_type;
   typedef enum logic {ROW_CSR, ROW_STEP} row_kind_type;

   typedef struct packed {
      logic lit;
      logic drv;
   } led_result_type;

   // For a step row the value is the timestamp; typed rows carry their result.
   typedef struct packed {
      row_kind_type      kind;
      logic [CSR_AW-1:0] addr;
      logic [31:0]       value;
      logic              typed;
      logic              lit;
      logic              drv;
   } script_row_type;

   localparam script_row_type SCRIPT [36] = '{
      '{ROW_STEP, REG_MODE,     32'h0000_0000,        1'b1, 1'b0, 1'b1},
      '{ROW_STEP, REG_MODE,     32'hFFFF_FFFF,        1'b1, 1'b0, 1'b0},
      '{ROW_CSR,  REG_MODE,     32'(MODE_ON),         1'b0, 1'b0, 1'b0},
      '{ROW_STEP, REG_MODE,     32'd5,                1'b1, 1'b1, 1'b1},
      '{ROW_STEP, REG_MODE,     32'd6,                1'b1, 1'b0, 1'b0},
      '{ROW_CSR,  REG_ON_TIME,  32'd0,                1'b0, 1'b0, 1'b0},
      '{ROW_CSR,  REG_OFF_TIME, 32'd0,                1'b0, 1'b0, 1'b0},
      '{ROW_CSR,  REG_MODE,     32'(MODE_BLINK),      1'b0, 1'b0, 1'b0},
      '{ROW_STEP, REG_MODE,     32'd0,                1'b1, 1'b1, 1'b1},
      '{ROW_STEP, REG_MODE,     32'd7,                1'b1, 1'b0, 1'b1},
      '{ROW_STEP, REG_MODE,     32'd7,                1'b1, 1'b1, 1'b1},
      '{ROW_CSR,  REG_ON_TIME,  32'hFFFF_FFFF,        1'b0, 1'b0, 1'b0},
      '{ROW_CSR,  REG_OFF_TIME, 32'd3,                1'b0, 1'b0, 1'b0},
      '{ROW_CSR,  REG_DURATION, 32'd10,               1'b0, 1'b0, 1'b0},
      '{ROW_CSR,  REG_MODE,     32'(MODE_BLINK),      1'b0, 1'b0, 1'b0},
      '{ROW_STEP, REG_MODE,     32'd100,              1'b0, 1'b0, 1'b0},
      '{ROW_STEP, REG_MODE,     32'd105,              1'b0, 1'b0, 1'b0},
      '{ROW_STEP, REG_MODE,     32'd110,              1'b0, 1'b0, 1'b0},
      '{ROW_STEP, REG_MODE,     32'hFFFF_FFF0,        1'b0, 1'b0, 1'b0},
      '{ROW_STEP, REG_MODE,     32'h0000_01E4,        1'b0, 1'b0, 1'b0},
      '{ROW_CSR,  REG_ON_TIME,  32'd20,               1'b0, 1'b0, 1'b0},
      '{ROW_STEP, REG_MODE,     32'h0000_01E5,        1'b0, 1'b0, 1'b0},
      '{ROW_CSR,  REG_PERIOD,   32'd0,                1'b0, 1'b0, 1'b0},
      '{ROW_CSR,  REG_MODE,     32'(MODE_BREATHE),    1'b0, 1'b0, 1'b0},
      '{ROW_STEP, REG_MODE,     32'd1,                1'b0, 1'b0, 1'b0},
      '{ROW_STEP, REG_MODE,     32'd2,                1'b0, 1'b0, 1'b0},
      '{ROW_STEP, REG_MODE,     32'd3,                1'b0, 1'b0, 1'b0},
      '{ROW_STEP, REG_MODE,     32'd4,                1'b0, 1'b0, 1'b0},
      '{ROW_STEP, REG_MODE,     32'd5,                1'b0, 1'b0, 1'b0},
      '{ROW_STEP, REG_MODE,     32'd6,                1'b0, 1'b0, 1'b0},
      '{ROW_CSR,  REG_PERIOD,   32'h0000_FFFF,        1'b0, 1'b0, 1'b0},
      '{ROW_STEP, REG_MODE,     32'd40,               1'b0, 1'b0, 1'b0},
      '{ROW_STEP, REG_MODE,     32'd400,              1'b0, 1'b0, 1'b0},
      '{ROW_CSR,  REG_MODE,     32'(MODE_OFF),        1'b0, 1'b0, 1'b0},
      '{ROW_STEP, REG_MODE,     32'd401,              1'b1, 1'b0, 1'b1},
      '{ROW_STEP, REG_MODE,     32'd402,              1'b1, 1'b0, 1'b0}
   };

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [31:0]       req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [7:0]        rsp_tdata;
   logic              csr_we;
   logic [CSR_AW-1:0] csr_addr;
   logic [CSR_DW-1:0] csr_wdata;

   // Predictor copy of the registers and of the core state.
   logic [TICK_W-1:0]   reg_on, reg_off, reg_dur;
   logic [PERIOD_W-1:0] reg_period;
   act_type             act_state;
   blink_ph_type        blink_ph;
   logic [TICK_W-1:0]   lit_at, dark_at, run_at, cur_on, cur_off, cur_limit, duty_at;
   logic [PWM_W-1:0]    pwm_ctr, duty;
   logic                duty_up;

   led_result_type due_results[$];
   int error_count, cycle_count;
   int n_steps, n_writes, n_phases, n_lit, n_driven;
   int send_gap_max, rcv_gap_max;

   led_blink_breathe_controller_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6ns clock = ~clock;

   task automatic flag_error(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   function automatic void restart_blink(input logic [TICK_W-1:0] on_t,
                                         input logic [TICK_W-1:0] off_t,
                                         input logic [TICK_W-1:0] limit);
      act_state = ACT_BLINK;
      blink_ph  = PH_FIRST;
      lit_at    = '0;
      dark_at   = '0;
      run_at    = '0;
      cur_on    = on_t;
      cur_off   = off_t;
      cur_limit = limit;
   endfunction

   function automatic void reset_led_state();
      reg_on     = BLINK_DEF_ON;
      reg_off    = BLINK_DEF_OFF;
      reg_dur    = '0;
      reg_period = '0;
      restart_blink(BLINK_DEF_ON, BLINK_DEF_OFF, '0);
      act_state  = ACT_OFF;
      pwm_ctr    = '0;
      duty       = '0;
      duty_up    = 1'b0;
      duty_at    = '0;
   endfunction

   function automatic void apply_register(input logic [CSR_AW-1:0] addr,
                                          input logic [CSR_DW-1:0] data);
      case (addr)
         REG_MODE: begin
            case (data[1:0])
               MODE_OFF:   act_state = ACT_OFF;
               MODE_ON:    act_state = ACT_ON;
               MODE_BLINK: restart_blink(reg_on, reg_off, reg_dur);
               default: begin
                  act_state = ACT_BREATHE;
                  pwm_ctr   = '0;
                  duty_at   = '0;
                  duty      = '0;
                  duty_up   = 1'b0;
               end
            endcase
         end
         REG_ON_TIME:  reg_on     = data;
         REG_OFF_TIME: reg_off    = data;
         REG_DURATION: reg_dur    = data;
         REG_PERIOD:   reg_period = data[PERIOD_W-1:0];
         default: ;
      endcase
   endfunction

   // Advances the predicted state by one service step and returns the LED word.
   function automatic led_result_type next_led_result(input logic [TICK_W-1:0] tick);
      led_result_type r;
      r = '0;
      case (act_state)
         ACT_OFF: begin
            r.drv     = 1'b1;
            act_state = ACT_IDLE;
         end
         ACT_ON: begin
            r.drv     = 1'b1;
            r.lit     = 1'b1;
            act_state = ACT_IDLE;
         end
         ACT_BLINK: begin
            if (cur_limit != '0 && blink_ph != PH_FIRST &&
                TICK_W'(tick - run_at) >= cur_limit) begin
               // A timed blink that runs out falls back to an endless default blink.
               r.drv = 1'b1;
               restart_blink(BLINK_DEF_ON, BLINK_DEF_OFF, '0);
            end else if (blink_ph == PH_LIT) begin
               if (TICK_W'(tick - lit_at) >= cur_on) begin
                  r.drv    = 1'b1;
                  dark_at  = tick;
                  blink_ph = PH_DARK;
               end
            end else if (blink_ph == PH_DARK) begin
               if (TICK_W'(tick - dark_at) >= cur_off) begin
                  r.drv    = 1'b1;
                  r.lit    = 1'b1;
                  lit_at   = tick;
                  blink_ph = PH_LIT;
               end
            end else begin
               r.drv    = 1'b1;
               r.lit    = 1'b1;
               lit_at   = tick;
               run_at   = tick;
               blink_ph = PH_LIT;
            end
         end
         ACT_BREATHE: begin
            pwm_ctr = pwm_ctr + 1'b1;
            r.drv   = 1'b1;
            r.lit   = (pwm_ctr < duty);
            if (pwm_ctr >= PWM_W'(PWM_STEPS))
               pwm_ctr = '0;
            if (TICK_W'(tick - duty_at) >= TICK_W'(reg_period / STEP_DIV)) begin
               duty_at = tick;
               if (duty_up) begin
                  if (duty < PWM_W'(PWM_STEPS))
                     duty = duty + 1'b1;
                  if (duty >= PWM_W'(PWM_STEPS))
                     duty_up = 1'b0;
               end else begin
                  if (duty > '0)
                     duty = duty - 1'b1;
                  if (duty == '0)
                     duty_up = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Holds the input side off until every outstanding word has come back.
   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (due_results.size() != 0);
      @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] data);
      wait_for_quiet();
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      apply_register(addr, data);
      csr_we <= 1'b0;
      n_writes++;
   endtask

   task automatic send_step(input logic [TICK_W-1:0] tick, input logic typed,
                            input led_result_type typed_res);
      int gap;
      led_result_type guess;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= tick;
      do @(posedge clock); while (!req_tready);
      guess = next_led_result(tick);
      due_results.push_back(typed ? typed_res : guess);
      n_steps++;
   endtask

   function automatic logic [31:0] pick_interval();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(0, 24);
      if (roll < 80) return '0;
      if (roll < 90) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   // Receiver side: random stall before each word, sometimes none at all.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         stall = $urandom_range(0, rcv_gap_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      led_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_results.size() == 0) begin
            flag_error($sformatf("word %02h arrived with nothing outstanding", rsp_tdata));
         end else begin
            want = due_results.pop_front();
            if (rsp_tdata[0] !== want.lit)
               flag_error($sformatf("led_on %b, predicted %b", rsp_tdata[0], want.lit));
            if (rsp_tdata[1] !== want.drv)
               flag_error($sformatf("led_driven %b, predicted %b", rsp_tdata[1], want.drv));
         end
         if (rsp_tdata[7:2] !== '0)
            flag_error($sformatf("pad bits of word %02h are not zero", rsp_tdata));
         n_lit    += int'(rsp_tdata[0] === 1'b1);
         n_driven += int'(rsp_tdata[1] === 1'b1);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycle_count, due_results.size());
         $display("tb_led_blink_breathe_controller_core: errors");
         $finish;
      end
   end

   initial begin
      logic [TICK_W-1:0] tick;
      logic [CSR_DW-1:0] wdata;
      logic [1:0]        mode_pick;
      int                roll, run_len;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_we       = 1'b0;
      csr_addr     = '0;
      csr_wdata    = '0;
      send_gap_max = 12;
      rcv_gap_max  = 12;
      reset_led_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (SCRIPT[i]) begin
         if (SCRIPT[i].kind == ROW_CSR)
            write_csr(SCRIPT[i].addr, SCRIPT[i].value);
         else
            send_step(SCRIPT[i].value, SCRIPT[i].typed, '{SCRIPT[i].lit, SCRIPT[i].drv});
      end

      tick = 32'd1000;
      while (n_steps < RANDOM_STEPS + 23) begin
         n_phases++;
         send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
         rcv_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 12;
         if ($urandom_range(0, 1) == 0) write_csr(REG_ON_TIME, pick_interval());
         if ($urandom_range(0, 1) == 0) write_csr(REG_OFF_TIME, pick_interval());
         if ($urandom_range(0, 1) == 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 40)      wdata = '0;
            else if (roll < 80) wdata = $urandom_range(1, 300);
            else if (roll < 90) wdata = 32'hFFFF_FFFF;
            else                wdata = $urandom;
            write_csr(REG_DURATION, wdata);
         end
         if ($urandom_range(0, 1) == 0) begin
            // Upper bits above the period field are junk now and then.
            wdata = ($urandom_range(0, 3) == 0) ? 32'($urandom) : '0;
            roll  = $urandom_range(0, 99);
            if (roll < 50)      wdata[15:0] = 16'($urandom_range(0, 2000));
            else if (roll < 70) wdata[15:0] = 16'($urandom_range(0, 199));
            else if (roll < 85) wdata[15:0] = 16'hFFFF;
            else                wdata[15:0] = 16'($urandom_range(0, 65535));
            write_csr(REG_PERIOD, wdata);
         end
         roll = $urandom_range(0, 99);
         if (roll < 40)      mode_pick = MODE_BLINK;
         else if (roll < 75) mode_pick = MODE_BREATHE;
         else if (roll < 87) mode_pick = MODE_ON;
         else                mode_pick = MODE_OFF;
         wdata      = ($urandom_range(0, 3) == 0) ? 32'($urandom) : '0;
         wdata[1:0] = mode_pick;
         write_csr(REG_MODE, wdata);

         case (mode_pick)
            MODE_BREATHE: run_len = $urandom_range(60, 260);
            MODE_BLINK:   run_len = $urandom_range(20, 120);
            default:      run_len = $urandom_range(2, 6);
         endcase
         if ($urandom_range(0, 4) == 0)
            tick = 32'hFFFF_FF00 + 32'($urandom_range(0, 255));
         repeat (run_len) begin
            roll = $urandom_range(0, 99);
            if (roll < 85)      tick = tick + 32'($urandom_range(0, 6));
            else if (roll < 95) tick = tick + 32'($urandom_range(0, 40));
            else                tick = $urandom;
            send_step(tick, 1'b0, '0);
            if ($urandom_range(0, 63) == 0)
               wait_for_quiet();
         end
      end

      wait_for_quiet();
      repeat (4) @(posedge clock);
      if (due_results.size() != 0)
         flag_error($sformatf("%0d predicted words never arrived", due_results.size()));
      $display("covered %0d steps over %0d random phases with %0d register writes",
               n_steps, n_phases, n_writes);
      $display("results seen: %0d driven, %0d lit", n_driven, n_lit);
      if (error_count == 0) begin
         $display("tb_led_blink_breathe_controller_core: clean");
      end else begin
         $display("tb_led_blink_breathe_controller_core: errors");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/lbbc_pkg.sv
hw/rtl/led_blink_breathe_controller_core.sv
dv/tb_led_blink_breathe_controller_core.sv
